>>> rtl/asn1t_pkg.sv
// Shared types, constants and the month table for the ASN.1 time converter.
// No dependencies; asn1t_year and asn1_time_to_epoch_seconds import it.
package asn1t_pkg;

    localparam int YEAR_W      = 14;
    localparam int DAYS_W      = 24;
    localparam int SOD_W       = 19;
    localparam int EPOCH_W     = 39;
    localparam int RECIP_SHIFT = 19;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 43690.
    localparam logic [12:0] RECIP_100 = 13'd5243;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_FORMAT = 2'd1,
        ERR_RANGE  = 2'd2,
        ERR_LOCAL  = 2'd3
    } t_err_code;

    typedef struct packed {
        logic signed [DAYS_W-1:0] ydays;
        logic                     leap;
        logic                     before_epoch;
    } t_year_info;

    // Days in the months before the given month.
    function automatic logic [8:0] cum_days(input logic [3:0] month, input logic leap);
        logic [8:0] base;
        begin
            case (month)
                4'd2:    base = 9'd31;
                4'd3:    base = 9'd59;
                4'd4:    base = 9'd90;
                4'd5:    base = 9'd120;
                4'd6:    base = 9'd151;
                4'd7:    base = 9'd181;
                4'd8:    base = 9'd212;
                4'd9:    base = 9'd243;
                4'd10:   base = 9'd273;
                4'd11:   base = 9'd304;
                4'd12:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && month > 4'd2) begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

endpackage

>>> rtl/asn1t_year.sv
// Year unit: day count from 1970-01-01 to January 1 of the year, leap flag.
// Registered once; depends on asn1t_pkg.
module asn1t_year import asn1t_pkg::*; (
    input  logic              i_clk,
    input  logic [YEAR_W-1:0] i_year,
    output t_year_info        o_info
);

    logic                     pre_epoch;
    logic [14:0]              cent_x;
    logic [27:0]              cent_prod;
    logic [8:0]               cent;
    logic [27:0]              q_prod;
    logic [6:0]               q100;
    logic [6:0]               rem100;
    logic                     leap;
    logic [11:0]              quad_a;
    logic [11:0]              ccnt_a;
    logic [11:0]              quad_b;
    logic [11:0]              cpart_b;
    logic signed [12:0]       adj;
    logic signed [DAYS_W-1:0] yrs;
    logic signed [DAYS_W-1:0] ydays;

    always_comb begin
        pre_epoch = i_year < YEAR_W'(1970);
        // Century index: ceil(year / 100) before 1970, floor((year - 1) / 100) after.
        cent_x    = pre_epoch ? (15'(i_year) + 15'd99) : (15'(i_year) - 15'd1);
        cent_prod = 28'(cent_x) * 28'(RECIP_100);
        cent      = 9'(cent_prod >> RECIP_SHIFT);

        q_prod = 28'(i_year) * 28'(RECIP_100);
        q100   = 7'(q_prod >> RECIP_SHIFT);
        rem100 = 7'(i_year - YEAR_W'(q100) * YEAR_W'(100));
        leap   = (i_year[1:0] == 2'd0) && ((rem100 != 7'd0) || (q100[1:0] == 2'd0));

        // From 1970 on: one day per fourth year, less the non-leap centuries from 2100.
        quad_a = 12'((i_year - YEAR_W'(1969)) >> 2);
        ccnt_a = 12'(cent) - 12'(cent >> 2) - 12'd15;
        // Before 1970: the same count backward, with the non-leap centuries up to 1900.
        quad_b  = 12'((YEAR_W'(1972) - i_year) >> 2);
        cpart_b = 12'd15 - 12'(cent) + 12'((cent + 9'd3) >> 2);

        // Years past 9999 can push the leap-day count beyond eleven bits.
        adj   = pre_epoch ? $signed(13'(cpart_b) - 13'(quad_b))
                          : $signed(13'(quad_a) - 13'(ccnt_a));
        yrs   = $signed(DAYS_W'(i_year)) - $signed(DAYS_W'(1970));
        ydays = yrs * $signed(DAYS_W'(365)) + DAYS_W'(adj);
    end

    always_ff @(posedge i_clk) begin
        o_info.ydays        <= ydays;
        o_info.leap         <= leap;
        o_info.before_epoch <= pre_epoch;
    end

endmodule

>>> rtl/asn1_time_to_epoch_seconds.sv
// ASN.1 UTCTime / GeneralizedTime string to signed seconds since 1970 UTC.
// One character is taken per cycle while o_stall is low. After the last character
// is accepted, the result is registered in a first stage for the day and time-of-day
// sums, then in a second stage for the multiply by 86400 and the sign check.
// Synchronous active-low reset clears the parser and the pipeline valid bits.
// Depends on asn1t_pkg and asn1t_year.
module asn1_time_to_epoch_seconds import asn1t_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_char_byte,
    input  logic                      i_is_generalized,
    input  logic                      i_is_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [EPOCH_W-1:0] o_epoch_seconds,
    output logic [1:0]                o_error_code
);

    typedef enum logic [10:0] {
        PH_YEAR    = 11'b000_0000_0001,
        PH_MON     = 11'b000_0000_0010,
        PH_DAY     = 11'b000_0000_0100,
        PH_HOUR    = 11'b000_0000_1000,
        PH_MIN     = 11'b000_0001_0000,
        PH_SEC_OPT = 11'b000_0010_0000,
        PH_SEC2    = 11'b000_0100_0000,
        PH_AFTER   = 11'b000_1000_0000,
        PH_OFFH    = 11'b001_0000_0000,
        PH_OFFM    = 11'b010_0000_0000,
        PH_END     = 11'b100_0000_0000
    } t_phase;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // Parser state.
    t_phase            r_phase, n_phase, t_ph;
    logic [1:0]        r_cnt, n_cnt, t_cnt;
    logic [YEAR_W-1:0] r_year, n_year, t_year;
    logic [3:0]        r_month, n_month, t_month;
    logic [4:0]        r_day, n_day, t_day;
    logic [4:0]        r_hour, n_hour, t_hour;
    logic [5:0]        r_min, n_min, t_min;
    logic [5:0]        r_sec, n_sec, t_sec;
    logic [9:0]        r_zone, n_zone, t_zone;
    logic              r_neg, n_neg, t_neg;
    logic              r_err, n_err, t_err;

    // Pipeline.
    logic                     r_s1_valid, n_s1_valid;
    logic signed [DAYS_W-1:0] r_s1_days;
    logic signed [SOD_W-1:0]  r_s1_sod;
    t_err_code                r_s1_code;
    logic                     r_s1_before;
    logic                     r_out_valid;
    logic signed [EPOCH_W-1:0] r_out_epoch;
    t_err_code                r_out_code;

    t_year_info        yinfo;
    logic              accept;
    logic              out_free;
    logic              s1_move;
    logic              gen;
    logic              dig;
    logic [3:0]        d;
    logic [6:0]        grp;
    logic [6:0]        v;
    logic [YEAR_W-1:0] yacc;
    logic [2:0]        cnt3;
    logic              do_zone;

    logic [8:0]               cum;
    logic signed [DAYS_W-1:0] days_c;
    logic signed [10:0]       off_c;
    logic signed [SOD_W-1:0]  sod_c;
    t_err_code                code_c;
    logic signed [40:0]       full_c;
    t_err_code                out_code_c;
    logic signed [EPOCH_W-1:0] out_epoch_c;

    asn1t_year u_year (
        .i_clk  (i_clk),
        .i_year (r_year),
        .o_info (yinfo)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    assign gen = i_is_generalized;
    assign dig = (i_char_byte >= CH_ZERO) && (i_char_byte <= CH_NINE);
    assign d   = dig ? 4'(i_char_byte - CH_ZERO) : 4'd0;

    // Character step: what the state becomes after this character.
    always_comb begin
        t_ph    = r_phase;
        t_cnt   = r_cnt;
        t_year  = r_year;
        t_month = r_month;
        t_day   = r_day;
        t_hour  = r_hour;
        t_min   = r_min;
        t_sec   = r_sec;
        t_zone  = r_zone;
        t_neg   = r_neg;
        t_err   = r_err;
        do_zone = 1'b0;
        yacc    = YEAR_W'(r_year * YEAR_W'(10) + YEAR_W'(d));
        cnt3    = 3'(r_cnt) + 3'd1;

        // The stored first digit of whichever two-digit group is open.
        unique case (r_phase)
            PH_MON:  grp = 7'(r_month);
            PH_DAY:  grp = 7'(r_day);
            PH_HOUR: grp = 7'(r_hour);
            PH_MIN:  grp = 7'(r_min);
            PH_SEC2: grp = 7'(r_sec);
            PH_OFFH: grp = 7'(r_zone);
            default: grp = 7'd0;
        endcase
        v = 7'(grp * 7'd10 + 7'(d));

        if (!r_err) begin
            unique case (r_phase)
                PH_YEAR: begin
                    if (!dig) begin
                        t_err = 1'b1;
                    end else begin
                        if (cnt3 >= (gen ? 3'd4 : 3'd2)) begin
                            if (!gen) begin
                                yacc = yacc + ((yacc < YEAR_W'(50)) ? YEAR_W'(2000)
                                                                     : YEAR_W'(1900));
                            end
                            t_cnt = 2'd0;
                            t_ph  = PH_MON;
                        end else begin
                            t_cnt = cnt3[1:0];
                        end
                        t_year = yacc;
                    end
                end
                PH_MON: begin
                    if (!dig) begin
                        t_err = 1'b1;
                    end else if (r_cnt == 2'd0) begin
                        t_month = d;
                        t_cnt   = 2'd1;
                    end else if (v < 7'd1 || v > 7'd12) begin
                        t_err = 1'b1;
                    end else begin
                        t_month = v[3:0];
                        t_cnt   = 2'd0;
                        t_ph    = PH_DAY;
                    end
                end
                PH_DAY: begin
                    if (!dig) begin
                        t_err = 1'b1;
                    end else if (r_cnt == 2'd0) begin
                        t_day = 5'(d);
                        t_cnt = 2'd1;
                    end else if (v < 7'd1 || v > 7'd31) begin
                        t_err = 1'b1;
                    end else begin
                        t_day = v[4:0];
                        t_cnt = 2'd0;
                        t_ph  = PH_HOUR;
                    end
                end
                PH_HOUR: begin
                    if (!dig) begin
                        t_err = 1'b1;
                    end else if (r_cnt == 2'd0) begin
                        t_hour = 5'(d);
                        t_cnt  = 2'd1;
                    end else if (v > 7'd23) begin
                        t_err = 1'b1;
                    end else begin
                        t_hour = v[4:0];
                        t_cnt  = 2'd0;
                        t_ph   = PH_MIN;
                    end
                end
                PH_MIN: begin
                    if (!dig) begin
                        t_err = 1'b1;
                    end else if (r_cnt == 2'd0) begin
                        t_min = 6'(d);
                        t_cnt = 2'd1;
                    end else if (v > 7'd59) begin
                        t_err = 1'b1;
                    end else begin
                        t_min = v[5:0];
                        t_cnt = 2'd0;
                        t_ph  = PH_SEC_OPT;
                    end
                end
                PH_SEC_OPT: begin
                    if (dig) begin
                        t_sec = 6'(d);
                        t_ph  = PH_SEC2;
                    end else begin
                        t_sec   = 6'd0;
                        t_ph    = PH_AFTER;
                        do_zone = 1'b1;
                    end
                end
                PH_SEC2: begin
                    if (!dig || v > 7'd59) begin
                        t_err = 1'b1;
                    end else begin
                        t_sec = v[5:0];
                        t_ph  = PH_AFTER;
                    end
                end
                PH_AFTER: begin
                    do_zone = 1'b1;
                end
                PH_OFFH: begin
                    if (!dig) begin
                        t_err = 1'b1;
                    end else if (r_cnt == 2'd0) begin
                        t_zone = 10'(d);
                        t_cnt  = 2'd1;
                    end else if (v > 7'd12) begin
                        t_err = 1'b1;
                    end else begin
                        t_zone = 10'(v) * 10'd60;
                        t_cnt  = 2'd0;
                        t_ph   = PH_OFFM;
                    end
                end
                PH_OFFM: begin
                    if (!dig) begin
                        t_err = 1'b1;
                    end else if (r_cnt == 2'd0) begin
                        if (d > 4'd5) begin
                            t_err = 1'b1;
                        end else begin
                            t_zone = r_zone + 10'(d) * 10'd10;
                            t_cnt  = 2'd1;
                        end
                    end else begin
                        t_zone = r_zone + 10'(d);
                        t_ph   = PH_END;
                    end
                end
                default: begin
                    // Anything after the zone is a format error.
                    t_err = 1'b1;
                end
            endcase

            // GeneralizedTime skips fraction characters until the zone shows up.
            if (do_zone) begin
                if (gen && (i_char_byte == CH_DOT || i_char_byte == CH_COMMA || dig)) begin
                    t_err = t_err;
                end else if (i_char_byte == CH_Z) begin
                    t_zone = 10'd0;
                    t_neg  = 1'b0;
                    t_ph   = PH_END;
                end else if (i_char_byte == CH_PLUS || i_char_byte == CH_MINUS) begin
                    t_neg  = (i_char_byte == CH_MINUS);
                    t_zone = 10'd0;
                    t_cnt  = 2'd0;
                    t_ph   = PH_OFFH;
                end else begin
                    t_err = 1'b1;
                end
            end
        end
    end

    // Next state: a string's last character returns the parser to its start.
    always_comb begin
        if (accept && i_is_last) begin
            n_phase = PH_YEAR;
            n_cnt   = 2'd0;
            n_year  = '0;
            n_month = '0;
            n_day   = '0;
            n_hour  = '0;
            n_min   = '0;
            n_sec   = '0;
            n_zone  = '0;
            n_neg   = 1'b0;
            n_err   = 1'b0;
        end else if (accept) begin
            n_phase = t_ph;
            n_cnt   = t_cnt;
            n_year  = t_year;
            n_month = t_month;
            n_day   = t_day;
            n_hour  = t_hour;
            n_min   = t_min;
            n_sec   = t_sec;
            n_zone  = t_zone;
            n_neg   = t_neg;
            n_err   = t_err;
        end else begin
            n_phase = r_phase;
            n_cnt   = r_cnt;
            n_year  = r_year;
            n_month = r_month;
            n_day   = r_day;
            n_hour  = r_hour;
            n_min   = r_min;
            n_sec   = r_sec;
            n_zone  = r_zone;
            n_neg   = r_neg;
            n_err   = r_err;
        end
    end

    // First result stage: total days and signed seconds within the day.
    always_comb begin
        cum    = cum_days(t_month, yinfo.leap);
        days_c = yinfo.ydays + $signed(DAYS_W'(cum)) + $signed(DAYS_W'(t_day))
                 - $signed(DAYS_W'(1));
        off_c  = t_neg ? -$signed(11'(t_zone)) : $signed(11'(t_zone));
        sod_c  = $signed(SOD_W'(t_sec))
                 + ($signed(SOD_W'(t_min)) - SOD_W'(off_c)) * $signed(SOD_W'(60))
                 + $signed(SOD_W'(t_hour)) * $signed(SOD_W'(3600));
        if (t_err) begin
            code_c = ERR_FORMAT;
        end else if (t_ph == PH_END) begin
            code_c = ERR_NONE;
        end else if (gen && (t_ph == PH_SEC_OPT || t_ph == PH_AFTER)) begin
            code_c = ERR_LOCAL;
        end else begin
            code_c = ERR_FORMAT;
        end
        n_s1_valid = (accept && i_is_last) ? 1'b1 : (s1_move ? 1'b0 : r_s1_valid);
    end

    // Second result stage: seconds and the check that the sign matches the year.
    always_comb begin
        full_c = 41'(r_s1_days) * $signed(41'(86400)) + 41'(r_s1_sod);
        if (r_s1_code != ERR_NONE) begin
            out_code_c  = r_s1_code;
            out_epoch_c = '0;
        end else if (r_s1_before ? !full_c[40] : full_c[40]) begin
            out_code_c  = ERR_RANGE;
            out_epoch_c = '0;
        end else begin
            out_code_c  = ERR_NONE;
            out_epoch_c = full_c[EPOCH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_YEAR;
            r_cnt       <= 2'd0;
            r_year      <= '0;
            r_month     <= '0;
            r_day       <= '0;
            r_hour      <= '0;
            r_min       <= '0;
            r_sec       <= '0;
            r_zone      <= '0;
            r_neg       <= 1'b0;
            r_err       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_year     <= n_year;
            r_month    <= n_month;
            r_day      <= n_day;
            r_hour     <= n_hour;
            r_min      <= n_min;
            r_sec      <= n_sec;
            r_zone     <= n_zone;
            r_neg      <= n_neg;
            r_err      <= n_err;
            r_s1_valid <= n_s1_valid;
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_is_last) begin
            r_s1_days   <= days_c;
            r_s1_sod    <= sod_c;
            r_s1_code   <= code_c;
            r_s1_before <= yinfo.before_epoch;
        end
        if (s1_move) begin
            r_out_epoch <= out_epoch_c;
            r_out_code  <= out_code_c;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_epoch_seconds = r_out_epoch;
    assign o_error_code    = r_out_code;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code != ERR_NONE) |-> (o_epoch_seconds == '0))
        else $error("result with an error code carries nonzero seconds");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a finished item in the first stage");

    a_parser_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_is_last) |=> (r_phase == PH_YEAR && !r_err
                                                && r_cnt == 2'd0))
        else $error("parser did not return to its start after the last character");
`endif

endmodule

>>> dv/asn1_time_to_epoch_seconds_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for asn1_time_to_epoch_seconds: table-driven and random time strings.
// Depends on asn1t_pkg and the RTL; results are checked against a built-in predictor or typed rows.
module asn1_time_to_epoch_seconds_tb;
    import asn1t_pkg::*;

    typedef enum logic [3:0] {
        P_YEAR, P_MON, P_DAY, P_HOUR, P_MIN, P_SEC_OPT, P_SEC2,
        P_AFTER, P_OFFH, P_OFFM, P_END
    } t_parse_phase;

    typedef struct packed {
        logic signed [EPOCH_W-1:0] epoch;
        t_err_code                 code;
    } t_time_result;

    typedef struct {
        string     text;
        bit        gen;
        int        flip;
        bit        typed;
        longint    epoch;
        t_err_code code;
    } t_dir_row;

    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int DIR_ROWS = 27;

    // In the table text a '#' stands for a NUL byte.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{"700101000000Z",        1'b0, -1, 1'b1, 64'sd0,            ERR_NONE},
        '{"99991231235959Z",      1'b1, -1, 1'b1, 64'sd253402300799, ERR_NONE},
        '{"99991231235959-1259",  1'b1, -1, 1'b1, 64'sd253402347539, ERR_NONE},
        '{"00000101000000+1259",  1'b1, -1, 1'b1, -64'sd62167265940, ERR_NONE},
        '{"7001010000",           1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"20240101000000",       1'b1, -1, 1'b1, 64'sd0,            ERR_LOCAL},
        '{"19691231235959-0001",  1'b1, -1, 1'b1, 64'sd0,            ERR_RANGE},
        '{"700101000000+0100",    1'b0, -1, 1'b1, 64'sd0,            ERR_RANGE},
        '{"701301000000Z",        1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"700100000000Z",        1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"700101240000Z",        1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"700101006000Z",        1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"700101000060Z",        1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"700101000000+1300",    1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"700101000000+0060",    1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"70a1010000Z",          1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"7001#1000000Z",        1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"700101000000Z0",       1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"7001",                 1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"700101000000+01",      1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"7001010000Z",          1'b0, -1, 1'b1, 64'sd0,            ERR_NONE},
        '{"Z",                    1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"700101000000.5Z",      1'b0, -1, 1'b1, 64'sd0,            ERR_FORMAT},
        '{"20240229123456.789Z",  1'b1, -1, 1'b0, 64'sd0,            ERR_NONE},
        '{"19000301000000,5+0530", 1'b1, -1, 1'b0, 64'sd0,           ERR_NONE},
        '{"4912312359Z",          1'b0, 9,  1'b0, 64'sd0,            ERR_NONE},
        '{"2020101000000Z",       1'b1, 2,  1'b0, 64'sd0,            ERR_NONE}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [7:0]                i_char_byte;
    logic                      i_is_generalized;
    logic                      i_is_last;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [EPOCH_W-1:0] o_epoch_seconds;
    logic [1:0]                o_error_code;

    asn1_time_to_epoch_seconds dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_char_byte      (i_char_byte),
        .i_is_generalized (i_is_generalized),
        .i_is_last        (i_is_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_epoch_seconds  (o_epoch_seconds),
        .o_error_code     (o_error_code)
    );

    // Predictor state, one copy of the parser fields.
    t_parse_phase pr_phase = P_YEAR;
    int unsigned  pr_cnt = 0, pr_year = 0, pr_mon = 0, pr_day = 0, pr_hour = 0;
    int unsigned  pr_min = 0, pr_sec = 0, pr_zone = 0;
    bit           pr_neg = 1'b0, pr_bad = 1'b0;

    t_time_result expected_times [$];
    t_time_result fixed_res;
    bit           fixed_pending = 1'b0;
    int           fail_count = 0;
    int           chars_sent = 0;
    bit           calm = 1'b0;
    bit           rx_hold_req = 1'b0;
    byte unsigned str_chars [$];
    bit           str_gen [$];

    function automatic void clear_fields();
        pr_phase = P_YEAR;
        pr_cnt = 0; pr_year = 0; pr_mon = 0; pr_day = 0; pr_hour = 0;
        pr_min = 0; pr_sec = 0; pr_zone = 0; pr_neg = 1'b0; pr_bad = 1'b0;
    endfunction

    // Two-digit group: the first digit is held, the second completes and range checks.
    function automatic void pair_digit(inout int unsigned fld, input bit dig,
                                       input int unsigned d, input int unsigned lo,
                                       input int unsigned hi, input t_parse_phase nxt);
        int unsigned v;
        if (!dig) begin
            pr_bad = 1'b1;
            return;
        end
        if (pr_cnt == 0) begin
            fld = d;
            pr_cnt = 1;
            return;
        end
        v = fld * 10 + d;
        if (v < lo || v > hi) begin
            pr_bad = 1'b1;
            return;
        end
        fld = v;
        pr_cnt = 0;
        pr_phase = nxt;
    endfunction

    function automatic void zone_char(byte unsigned c, bit gen, bit dig);
        // GeneralizedTime fraction characters are skipped.
        if (gen && (c == "." || c == "," || dig)) return;
        if (c == "Z") begin
            pr_zone = 0;
            pr_neg = 1'b0;
            pr_phase = P_END;
        end else if (c == "+" || c == "-") begin
            pr_neg = (c == "-");
            pr_zone = 0;
            pr_cnt = 0;
            pr_phase = P_OFFH;
        end else begin
            pr_bad = 1'b1;
        end
    endfunction

    function automatic void parse_char(byte unsigned c, bit gen);
        bit          dig;
        int unsigned d, v;
        dig = (c >= "0" && c <= "9");
        d = dig ? c - 8'd48 : 0;
        case (pr_phase)
            P_YEAR: begin
                if (!dig) begin
                    pr_bad = 1'b1;
                end else begin
                    pr_year = (pr_year * 10 + d) & 32'h3FFF;
                    pr_cnt++;
                    if (pr_cnt >= (gen ? 4 : 2)) begin
                        if (!gen) pr_year += (pr_year < 50) ? 2000 : 1900;
                        pr_cnt = 0;
                        pr_phase = P_MON;
                    end
                end
            end
            P_MON:  pair_digit(pr_mon, dig, d, 1, 12, P_DAY);
            P_DAY:  pair_digit(pr_day, dig, d, 1, 31, P_HOUR);
            P_HOUR: pair_digit(pr_hour, dig, d, 0, 23, P_MIN);
            P_MIN:  pair_digit(pr_min, dig, d, 0, 59, P_SEC_OPT);
            P_SEC_OPT: begin
                if (dig) begin
                    pr_sec = d;
                    pr_phase = P_SEC2;
                end else begin
                    pr_sec = 0;
                    pr_phase = P_AFTER;
                    zone_char(c, gen, dig);
                end
            end
            P_SEC2: begin
                v = pr_sec * 10 + d;
                if (!dig || v > 59) begin
                    pr_bad = 1'b1;
                end else begin
                    pr_sec = v;
                    pr_phase = P_AFTER;
                end
            end
            P_AFTER: zone_char(c, gen, dig);
            P_OFFH: begin
                if (!dig) begin
                    pr_bad = 1'b1;
                end else if (pr_cnt == 0) begin
                    pr_zone = d;
                    pr_cnt = 1;
                end else begin
                    v = pr_zone * 10 + d;
                    if (v > 12) begin
                        pr_bad = 1'b1;
                    end else begin
                        pr_zone = v * 60;
                        pr_cnt = 0;
                        pr_phase = P_OFFM;
                    end
                end
            end
            P_OFFM: begin
                if (!dig) begin
                    pr_bad = 1'b1;
                end else if (pr_cnt == 0) begin
                    if (d > 5) begin
                        pr_bad = 1'b1;
                    end else begin
                        pr_zone += d * 10;
                        pr_cnt = 1;
                    end
                end else begin
                    pr_zone += d;
                    pr_phase = P_END;
                end
            end
            default: pr_bad = 1'b1;
        endcase
    endfunction

    function automatic t_time_result epoch_of_fields();
        int           yr, k;
        bit           leap;
        longint       r, off;
        t_time_result res;
        yr = int'(pr_year);
        off = pr_neg ? -longint'(pr_zone) : longint'(pr_zone);
        r = longint'(pr_sec) + (longint'(pr_min) - off) * 60;
        r += longint'(pr_hour) * 3600 + (longint'(pr_day) - 1) * 86400;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        for (k = int'(pr_mon) - 2; k >= 0 && k < 12; k--)
            r += longint'(MONTH_DAYS[k] + ((leap && k == 1) ? 1 : 0)) * 86400;
        r += (longint'(yr) - 1970) * 31536000;
        res.code = ERR_NONE;
        // Leap days and skipped century leap days on either side of 1970.
        if (yr < 1970) begin
            r -= longint'((1970 - yr + 2) / 4) * 86400;
            for (k = 1900; k >= yr; k -= 100)
                if (k % 400 != 0) r += 86400;
            if (r >= 0) res.code = ERR_RANGE;
        end else begin
            r += longint'((yr - 1970 + 1) / 4) * 86400;
            for (k = 2100; k < yr; k += 100)
                if (k % 400 != 0) r -= 86400;
            if (r < 0) res.code = ERR_RANGE;
        end
        res.epoch = (res.code != ERR_NONE) ? '0 : r[EPOCH_W-1:0];
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    // Predict on every accepted item, check every accepted result.
    always @(posedge i_clk) begin
        t_time_result want;
        if (i_rst_n && i_valid && !o_stall) begin
            if (!pr_bad) parse_char(i_char_byte, i_is_generalized);
            if (i_is_last) begin
                want.epoch = '0;
                if (pr_bad) begin
                    want.code = ERR_FORMAT;
                end else if (pr_phase == P_END) begin
                    want = epoch_of_fields();
                end else if (i_is_generalized && (pr_phase == P_SEC_OPT || pr_phase == P_AFTER)) begin
                    want.code = ERR_LOCAL;
                end else begin
                    want.code = ERR_FORMAT;
                end
                if (fixed_pending) begin
                    want = fixed_res;
                    fixed_pending = 1'b0;
                end
                expected_times.push_back(want);
                clear_fields();
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_times.size() == 0) begin
                $error("unexpected result: epoch_seconds %0d, error_code %0d",
                       o_epoch_seconds, o_error_code);
                fail_count++;
            end else begin
                want = expected_times.pop_front();
                if (o_epoch_seconds !== want.epoch) begin
                    $error("epoch_seconds: expected %0d, actual %0d",
                           $signed(want.epoch), o_epoch_seconds);
                    fail_count++;
                end
                if (o_error_code !== want.code) begin
                    $error("error_code: expected %0d, actual %0d", want.code, o_error_code);
                    fail_count++;
                end
            end
        end
    end

    // Result side: random stalls, one long hold-off on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_stall <= 1'b1;
                repeat (60) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < 12);
            end
        end
    end

    task automatic send_char(input byte unsigned c, input bit gen, input bit last);
        while (!calm && $urandom_range(0, 99) < 12) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_char_byte      <= c;
        i_is_generalized <= gen;
        i_is_last        <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        chars_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_chars.size(); i++)
            send_char(str_chars[i], str_gen[i], i == str_chars.size() - 1);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        wait (expected_times.size() == 0);
        @(negedge i_clk);
    endtask

    function automatic void add_char(byte unsigned c, bit gen);
        str_chars.push_back(c);
        str_gen.push_back(gen);
    endfunction

    function automatic void add_digits(int unsigned value, int width, bit gen);
        int unsigned scale;
        scale = 1;
        repeat (width - 1) scale *= 10;
        repeat (width) begin
            add_char(8'd48 + (value / scale) % 10, gen);
            scale /= 10;
        end
    endfunction

    // Mostly in range, now and then any two-digit value.
    function automatic int unsigned field_value(int unsigned lo, int unsigned hi);
        if ($urandom_range(0, 99) < 3) return $urandom_range(0, 99);
        return $urandom_range(lo, hi);
    endfunction

    function automatic void build_time_string();
        bit gen;
        int n, pos, kind;
        str_chars.delete();
        str_gen.delete();
        gen = $urandom_range(0, 1);
        if ($urandom_range(0, 99) < 6) begin
            n = $urandom_range(1, 20);
            repeat (n) add_char($urandom_range(0, 255), $urandom_range(0, 1));
            return;
        end
        if (gen)
            add_digits(($urandom_range(0, 99) < 80) ? $urandom_range(1900, 2150)
                                                   : $urandom_range(0, 9999), 4, gen);
        else
            add_digits($urandom_range(0, 99), 2, gen);
        add_digits(field_value(1, 12), 2, gen);
        add_digits(field_value(1, 31), 2, gen);
        add_digits(field_value(0, 23), 2, gen);
        add_digits(field_value(0, 59), 2, gen);
        if ($urandom_range(0, 99) < 70) add_digits(field_value(0, 59), 2, gen);
        if (gen && $urandom_range(0, 99) < 30) begin
            add_char($urandom_range(0, 1) ? "." : ",", gen);
            repeat ($urandom_range(0, 4))
                add_char(($urandom_range(0, 9) == 0) ? "." : 8'd48 + $urandom_range(0, 9), gen);
        end
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            add_char("Z", gen);
        end else if (kind < 90) begin
            add_char($urandom_range(0, 1) ? "+" : "-", gen);
            add_digits(field_value(0, 12), 2, gen);
            add_digits(field_value(0, 59), 2, gen);
        end
        if ($urandom_range(0, 99) < 12) begin
            pos = $urandom_range(0, str_chars.size() - 1);
            case ($urandom_range(0, 3))
                0: str_chars[pos] = $urandom_range(0, 255);
                1: while (str_chars.size() > pos + 1) begin
                    void'(str_chars.pop_back());
                    void'(str_gen.pop_back());
                end
                2: add_char($urandom_range(0, 255), gen);
                default: str_gen[pos] = !str_gen[pos];
            endcase
        end
    endfunction

    initial begin
        int          str_n, rand_start;
        longint      typed_epoch;
        byte unsigned c;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_char_byte      = '0;
        i_is_generalized = 1'b0;
        i_is_last        = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIR_ROWS; n++) begin
            str_chars.delete();
            str_gen.delete();
            for (int i = 0; i < dir_rows[n].text.len(); i++) begin
                c = dir_rows[n].text[i];
                if (c == "#") c = 8'h00;
                add_char(c, dir_rows[n].gen ^ (dir_rows[n].flip >= 0 && i >= dir_rows[n].flip));
            end
            if (dir_rows[n].typed) begin
                typed_epoch = dir_rows[n].epoch;
                fixed_res.epoch = typed_epoch[EPOCH_W-1:0];
                fixed_res.code = dir_rows[n].code;
                fixed_pending = 1'b1;
            end
            send_string();
        end
        drain_results();

        str_n = 0;
        rand_start = chars_sent;
        while (chars_sent - rand_start < 830) begin
            str_n++;
            calm = (str_n >= 30 && str_n < 45);
            // The receiver holds off while items keep coming, so the block backs up.
            if (str_n == 10) rx_hold_req = 1'b1;
            if (str_n % 25 == 0) drain_results();
            build_time_string();
            send_string();
        end
        calm = 1'b0;

        i_valid <= 1'b0;
        wait (expected_times.size() == 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && expected_times.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/asn1t_pkg.sv
rtl/asn1t_year.sv
rtl/asn1_time_to_epoch_seconds.sv
dv/asn1_time_to_epoch_seconds_tb.sv
